// File: hw/rtl/gprmc_pkg.sv
// Shared types, character codes and helper functions for the GPRMC time parser.
`default_nettype none

package gprmc_pkg;

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_G      = 8'h47;
    localparam logic [7:0] C_P      = 8'h50;
    localparam logic [7:0] C_R      = 8'h52;
    localparam logic [7:0] C_M      = 8'h4D;
    localparam logic [7:0] C_C      = 8'h43;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_A      = 8'h41;
    localparam logic [7:0] C_F      = 8'h46;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_ZERO   = 8'h30;

    localparam int unsigned HDR_LEN     = 6;
    localparam int unsigned TIME_DIGITS = 6;
    localparam logic [3:0]  POS_TIME_LO = 4'd7;
    localparam logic [3:0]  POS_TIME_HI = 4'd12;
    localparam logic [3:0]  POS_MAX     = 4'd15;
    localparam logic [4:0]  ZONE_RESET  = 5'd8;

    typedef struct packed {
        logic       sentence_accepted;
        logic [4:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } t_result;

    // Expected header character at positions 0..5.
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = C_DOLLAR;
            3'd1:    ch = C_G;
            3'd2:    ch = C_P;
            3'd3:    ch = C_R;
            3'd4:    ch = C_M;
            3'd5:    ch = C_C;
            default: ch = C_DOLLAR;
        endcase
        return ch;
    endfunction

    // 'A'..'F' map to 10..15, everything else is code minus '0', kept to 12 bits.
    function automatic logic [11:0] hex_value(input logic [7:0] ch);
        logic [11:0] v;
        if (ch >= C_A && ch <= C_F) begin
            v = {4'd0, ch} - {4'd0, C_A} + 12'd10;
        end else begin
            v = {4'd0, ch} - {4'd0, C_ZERO};
        end
        return v;
    endfunction

    // Two decimal digits to a binary value, max 165.
    function automatic logic [7:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
        return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'd0, lo};
    endfunction

    // h mod 24 for h <= 196: reciprocal multiply by 171/4096, never overshoots here.
    function automatic logic [4:0] mod24(input logic [7:0] h);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = {8'd0, h} * 16'd171;
        q    = prod[15:12];
        r    = h - ({4'd0, q} * 8'd24);
        return r[4:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gprmc_core.sv
// Per-character sentence state, checksum and status checks, held time update.
`default_nettype none

module gprmc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_last,
    input  wire logic [4:0]        i_zone,
    output logic                   o_push,
    output gprmc_pkg::t_result     o_result
);
    import gprmc_pkg::*;

    logic [3:0]  r_pos;
    logic        r_hdr_ok;
    logic [7:0]  r_xor;
    logic        r_star;
    logic [1:0]  r_taken;
    logic [11:0] r_chk;
    logic        r_comma;
    logic        r_pending;
    logic        r_status_a;
    logic [3:0]  r_digit [TIME_DIGITS];
    logic [4:0]  r_hours;
    logic [6:0]  r_minutes;
    logic [6:0]  r_seconds;

    logic        n_hdr_ok;
    logic [7:0]  n_xor;
    logic        n_star;
    logic [1:0]  n_taken;
    logic [11:0] n_chk;
    logic        n_comma;
    logic        n_pending;
    logic        n_status_a;
    logic [3:0]  n_digit [TIME_DIGITS];
    logic        ok;
    logic [7:0]  hour_sum;
    logic [7:0]  min_sum;
    logic [7:0]  sec_sum;

    always_comb begin
        n_hdr_ok   = r_hdr_ok;
        n_xor      = r_xor;
        n_star     = r_star;
        n_taken    = r_taken;
        n_chk      = r_chk;
        n_comma    = r_comma;
        n_pending  = r_pending;
        n_status_a = r_status_a;

        if (r_pos < 4'(HDR_LEN) && i_char != hdr_char(r_pos[2:0])) begin
            n_hdr_ok = 1'b0;
        end

        if (r_pos != 4'd0 && !r_star) begin
            if (i_char == C_STAR) begin
                n_star = 1'b1;
            end else begin
                n_xor = r_xor ^ i_char;
            end
        end else if (r_star && r_taken < 2'd2) begin
            n_chk   = {r_chk[7:0], 4'd0} + hex_value(i_char);
            n_taken = r_taken + 2'd1;
        end

        if (r_pending) begin
            n_status_a = (i_char == C_A);
            n_pending  = 1'b0;
        end else if (!r_comma && r_pos >= POS_TIME_LO
                     && (i_char == C_COMMA || i_char == C_STAR)) begin
            n_comma   = 1'b1;
            n_pending = 1'b1;
        end

        for (int k = 0; k < TIME_DIGITS; k++) begin
            n_digit[k] = (r_pos == POS_TIME_LO + 4'(k)) ? i_char[3:0] : r_digit[k];
        end

        ok = n_hdr_ok && (r_pos >= 4'(HDR_LEN)) && n_star && (n_taken == 2'd2)
             && (n_chk == {4'd0, n_xor}) && n_comma && !n_pending && n_status_a;

        hour_sum = two_digits(n_digit[0], n_digit[1]) + {3'd0, i_zone};
        min_sum  = two_digits(n_digit[2], n_digit[3]);
        sec_sum  = two_digits(n_digit[4], n_digit[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hdr_ok   <= 1'b1;
            r_xor      <= '0;
            r_star     <= 1'b0;
            r_taken    <= '0;
            r_chk      <= '0;
            r_comma    <= 1'b0;
            r_pending  <= 1'b0;
            r_status_a <= 1'b0;
            for (int k = 0; k < TIME_DIGITS; k++) r_digit[k] <= '0;
            r_hours    <= '0;
            r_minutes  <= '0;
            r_seconds  <= '0;
        end else if (i_valid) begin
            if (i_last) begin
                // end of sentence: back to a clean slate, held time kept unless the sentence is accepted
                r_pos      <= '0;
                r_hdr_ok   <= 1'b1;
                r_xor      <= '0;
                r_star     <= 1'b0;
                r_taken    <= '0;
                r_chk      <= '0;
                r_comma    <= 1'b0;
                r_pending  <= 1'b0;
                r_status_a <= 1'b0;
                for (int k = 0; k < TIME_DIGITS; k++) r_digit[k] <= '0;
                if (ok) begin
                    r_hours   <= mod24(hour_sum);
                    r_minutes <= min_sum[6:0];
                    r_seconds <= sec_sum[6:0];
                end
            end else begin
                r_pos      <= (r_pos == POS_MAX) ? r_pos : r_pos + 4'd1;
                r_hdr_ok   <= n_hdr_ok;
                r_xor      <= n_xor;
                r_star     <= n_star;
                r_taken    <= n_taken;
                r_chk      <= n_chk;
                r_comma    <= n_comma;
                r_pending  <= n_pending;
                r_status_a <= n_status_a;
                for (int k = 0; k < TIME_DIGITS; k++) r_digit[k] <= n_digit[k];
            end
        end
    end

    always_comb begin
        o_push                     = i_valid && i_last;
        o_result.sentence_accepted = ok;
        o_result.hours             = ok ? mod24(hour_sum) : r_hours;
        o_result.minutes           = ok ? min_sum[6:0]    : r_minutes;
        o_result.seconds           = ok ? sec_sum[6:0]    : r_seconds;
    end

endmodule

`default_nettype wire

// File: hw/rtl/gprmc_obuf.sv
// Two-entry result queue: result register plus skid slot towards the output channel.
`default_nettype none

module gprmc_obuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire gprmc_pkg::t_result i_result,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output gprmc_pkg::t_result      o_result
);
    import gprmc_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop      = (r_count != 2'd0) && !i_stall;
    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gprmc_time_sentence_parser_top.sv
// Top level of the GPRMC time sentence parser: input register, parser core, result queue.
// A result passes from the input register through the core into the result queue.
// Throughput: one character per cycle; a last character waits in the input register only
//   while both result slots are occupied.
// Reset: synchronous, active low; clears the sentence state, the held time (00:00:00),
//   the input register and the result queue, and loads the zone offset with 8 hours.
`default_nettype none

module gprmc_time_sentence_parser_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // character channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_last_char,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_sentence_accepted,
    output logic [4:0]      o_hours,
    output logic [6:0]      o_minutes,
    output logic [6:0]      o_seconds,
    // zone offset register write
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [4:0] i_cfg_data
);
    import gprmc_pkg::*;

    // Input register: one character held between the port and the parser core.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic [4:0] r_zone;

    logic       load;
    logic       advance;
    logic       push;
    logic       full;
    t_result    core_result;
    t_result    out_result;

    // Only a last character needs a free result slot; other characters always move on.
    assign advance    = r_in_valid && !(r_in_last && full);
    assign o_in_stall = r_in_valid && !advance;
    assign load       = i_in_valid && !o_in_stall;

    // Register writes are accepted in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_zone <= i_cfg_data;
        end
    end

    // Per-character checks and the held time; emits one result per sentence.
    gprmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_zone   (r_zone),
        .o_push   (push),
        .o_result (core_result)
    );

    // Result register and skid slot, so one waiting result never blocks new characters.
    gprmc_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_sentence_accepted = out_result.sentence_accepted;
    assign o_hours             = out_result.hours;
    assign o_minutes           = out_result.minutes;
    assign o_seconds           = out_result.seconds;

endmodule

`default_nettype wire

// File: hw/rtl/gprmc_checker.sv
// Port-level checker for the GPRMC time parser, bound to the top level.
`default_nettype none

module gprmc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_last_char,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_sentence_accepted,
    input wire logic [4:0] o_hours,
    input wire logic [6:0] o_minutes,
    input wire logic [6:0] o_seconds
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sentence_accepted)
        && $stable(o_hours) && $stable(o_minutes) && $stable(o_seconds))
        else $error("result changed while stalled");

    // wrapped hour always in range
    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hours < 5'd24)
        else $error("hour out of range");

    // queue empties and input opens straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not cleared by reset");

    // a result appearing on an empty output comes from a last character that passed the input register
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_char, 2))
        else $error("result without a closing character transaction");

endmodule

bind gprmc_time_sentence_parser_top gprmc_checker u_gprmc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .i_last_char         (i_last_char),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_sentence_accepted (o_sentence_accepted),
    .o_hours             (o_hours),
    .o_minutes           (o_minutes),
    .o_seconds           (o_seconds)
);

`default_nettype wire

// File: tb/gprmc_time_checker.sv
// Checker for the GPRMC time parser: predicts each sentence result and compares it.
`default_nettype none

module gprmc_time_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_last_char,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic       i_sentence_accepted,
    input  wire logic [4:0] i_hours,
    input  wire logic [6:0] i_minutes,
    input  wire logic [6:0] i_seconds,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic [4:0] i_cfg_data,
    output int unsigned     o_fail_count,
    output int unsigned     o_outstanding,
    output int unsigned     o_results,
    output int unsigned     o_accepted_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import gprmc_pkg::*;

    localparam logic [47:0] HDR_TEXT = {C_DOLLAR, C_G, C_P, C_R, C_M, C_C};

    // predicted parser state
    logic [4:0]  zone;
    logic [3:0]  pos;
    logic        hdr_good;
    logic [7:0]  sum_calc;
    logic        star;
    logic [1:0]  hex_cnt;
    logic [11:0] sum_rx;
    logic        comma;
    logic        status_next;
    logic        status_a;
    logic [3:0]  tdig [6];
    logic [4:0]  held_h;
    logic [6:0]  held_m;
    logic [6:0]  held_s;

    t_result time_reports_due[$];
    t_result predicted;
    t_result want;
    logic    produced;

    task automatic clear_sentence_state();
        pos         = '0;
        hdr_good    = 1'b1;
        sum_calc    = '0;
        star        = 1'b0;
        hex_cnt     = '0;
        sum_rx      = '0;
        comma       = 1'b0;
        status_next = 1'b0;
        status_a    = 1'b0;
        for (int i = 0; i < 6; i++) tdig[i] = '0;
    endtask

    task automatic advance_parser(input logic [7:0] ch, input logic last,
                                  output logic emit, output t_result res);
        logic [3:0]  p;
        logic [11:0] digit;
        logic        good;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        p = pos;
        if (p < 6 && ch != HDR_TEXT[47 - 8*p -: 8]) hdr_good = 1'b0;

        if (p >= 1 && !star) begin
            if (ch == C_STAR) star = 1'b1;
            else sum_calc = sum_calc ^ ch;
        end else if (star && hex_cnt < 2) begin
            if (ch >= C_A && ch <= C_F) digit = {4'd0, ch} - {4'd0, C_A} + 12'd10;
            else digit = {4'd0, ch} - {4'd0, C_ZERO};
            sum_rx  = {sum_rx[7:0], 4'd0} + digit;
            hex_cnt = hex_cnt + 1'b1;
        end

        // status is the character following the first ',' or '*' from position 7
        if (status_next) begin
            status_a    = (ch == C_A);
            status_next = 1'b0;
        end else if (!comma && p >= 7 && (ch == C_COMMA || ch == C_STAR)) begin
            comma       = 1'b1;
            status_next = 1'b1;
        end

        if (p >= POS_TIME_LO && p <= POS_TIME_HI) tdig[3'(p - POS_TIME_LO)] = ch[3:0];
        if (pos != POS_MAX) pos = pos + 1'b1;

        emit = last;
        res  = '0;
        if (last) begin
            good = hdr_good && p >= 6 && star && hex_cnt == 2 &&
                   sum_rx == {4'd0, sum_calc} && comma && !status_next && status_a;
            if (good) begin
                hh     = tdig[0] * 10 + tdig[1] + zone;
                mm     = tdig[2] * 10 + tdig[3];
                ss     = tdig[4] * 10 + tdig[5];
                held_h = 5'(hh % 24);
                held_m = mm[6:0];
                held_s = ss[6:0];
            end
            res.sentence_accepted = good;
            res.hours             = held_h;
            res.minutes           = held_m;
            res.seconds           = held_s;
            clear_sentence_state();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            zone   = ZONE_RESET;
            held_h = '0;
            held_m = '0;
            held_s = '0;
            clear_sentence_state();
            time_reports_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) zone = i_cfg_data;

            if (i_in_valid && !i_in_stall) begin
                advance_parser(i_char_code, i_last_char, produced, predicted);
                if (produced) begin
                    time_reports_due.push_back(predicted);
                    if (predicted.sentence_accepted) o_accepted_count++;
                end
            end

            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (time_reports_due.size() == 0) begin
                    $error("result with no sentence outstanding: ok=%0d %0d:%0d:%0d",
                           i_sentence_accepted, i_hours, i_minutes, i_seconds);
                    o_fail_count++;
                end else begin
                    want = time_reports_due.pop_front();
                    if (i_sentence_accepted !== want.sentence_accepted) begin
                        $error("sentence_accepted: expected %0d, got %0d",
                               want.sentence_accepted, i_sentence_accepted);
                        o_fail_count++;
                    end
                    if (i_hours !== want.hours) begin
                        $error("hours: expected %0d, got %0d", want.hours, i_hours);
                        o_fail_count++;
                    end
                    if (i_minutes !== want.minutes) begin
                        $error("minutes: expected %0d, got %0d", want.minutes, i_minutes);
                        o_fail_count++;
                    end
                    if (i_seconds !== want.seconds) begin
                        $error("seconds: expected %0d, got %0d", want.seconds, i_seconds);
                        o_fail_count++;
                    end
                end
            end
        end
        o_outstanding = time_reports_due.size();
    end

endmodule

`default_nettype wire

// File: tb/gprmc_time_sentence_parser_top_test.sv
// Testbench top for the GPRMC time parser: stimulus, idling, watchdog and verdict.
`default_nettype none

module gprmc_time_sentence_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gprmc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 300;   // receiver hold-off, long enough to back up the input
    localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction before giving up
    localparam int DRAIN_PAUSE   = 6;     // settling pause once all results are taken
    localparam int RANDOM_ITEMS  = 450;
    localparam int MIN_SENTENCES = 18;
    localparam int PHASE_ITEMS   = 70;
    localparam int PHASE_SENT    = 3;

    // "$GPRMC," - header plus the field separator that precedes the time
    localparam logic [55:0] PREFIX = {C_DOLLAR, C_G, C_P, C_R, C_M, C_C, C_COMMA};
    localparam logic [7:0]  CH_DOT = 8'h2E;
    localparam logic [7:0]  CH_CR  = 8'h0D;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    // hex digit whose printed form is 'A', so the checksum can double as a status
    localparam logic [3:0]  STATUS_NIBBLE = 4'hA;

    typedef enum {
        SK_GOOD,        // well formed, status mostly 'A'
        SK_BAD_SUM,     // checksum digit replaced
        SK_BAD_HDR,     // one header character corrupted
        SK_NO_STAR,     // ends without a '*'
        SK_SHORT_SUM,   // ends before the last checksum digit
        SK_NO_STATUS,   // ends straight after the comma that opens the status
        SK_STAR_STATUS, // no comma after the time, status taken after '*'
        SK_NOISE,       // random bytes
        SK_TINY         // truncated header, under seven characters mostly
    } t_sentence_kind;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] char_code    = '0;
    logic       last_char    = 1'b0;
    logic       out_stall    = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic [4:0] cfg_data     = '0;
    wire        in_stall;
    wire        out_valid;
    wire        sentence_accepted;
    wire  [4:0] hours;
    wire  [6:0] minutes;
    wire  [6:0] seconds;
    wire        cfg_ready;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned accepted_seen;

    int  send_idle_pct = IDLE_PCT;
    int  recv_idle_pct = IDLE_PCT;
    logic hold_req     = 1'b0;
    int  holds_done    = 0;
    int  chars_sent    = 0;
    int  sentences_sent = 0;
    int  cfg_writes    = 0;
    int  quiet         = 0;

    logic [7:0] line[$];   // sentence being assembled

    always #HALF_PERIOD clk = ~clk;

    gprmc_time_sentence_parser_top DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_char_code         (char_code),
        .i_last_char         (last_char),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_sentence_accepted (sentence_accepted),
        .o_hours             (hours),
        .o_minutes           (minutes),
        .o_seconds           (seconds),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data)
    );

    gprmc_time_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_char_code         (char_code),
        .i_last_char         (last_char),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_sentence_accepted (sentence_accepted),
        .i_hours             (hours),
        .i_minutes           (minutes),
        .i_seconds           (seconds),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_outstanding       (outstanding),
        .o_results           (results_seen),
        .o_accepted_count    (accepted_seen)
    );

    // Watchdog: any transaction on any channel resets the quiet count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet, outstanding);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Result side: random stall, or one long hold-off counted here so the sender
    // keeps offering characters until the parser backs up and stalls its input.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && holds_done == 0) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // One character transaction; valid stays high into the next call unless it idles,
    // so valid is never dropped and raised within one step.
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        last_char <= last;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    task automatic send_line();
        for (int k = 0; k < line.size(); k++) send_char(line[k], k == line.size() - 1);
        sentences_sent++;
    endtask

    // Wait until every predicted result has been taken, then let the pipe settle.
    task automatic drain();
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [4:0] zone);
        cfg_valid <= 1'b1;
        cfg_data  <= zone;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return 8'((v < 10) ? C_ZERO + v : C_A + v - 10);
    endfunction

    // XOR over everything after the '$' that has been assembled so far
    function automatic logic [7:0] body_xor();
        logic [7:0] x;
        x = '0;
        for (int k = 1; k < line.size(); k++) x = x ^ line[k];
        return x;
    endfunction

    task automatic append_checksum();
        logic [7:0] x;
        x = body_xor();
        line.push_back(C_STAR);
        line.push_back(hex_char(x[7:4]));
        line.push_back(hex_char(x[3:0]));
    endtask

    task automatic push_prefix(input int n);
        for (int k = 0; k < n; k++) line.push_back(PREFIX[55 - 8*k -: 8]);
    endtask

    // Decimal digit from 0 up to hi; now and then any byte at all.
    task automatic push_digit(input int hi);
        logic [7:0] b;
        if ($urandom_range(0, 11) == 0) b = 8'($urandom_range(0, 255));
        else b = 8'(C_ZERO + $urandom_range(0, hi));
        line.push_back(b);
    endtask

    task automatic make_sentence(input t_sentence_kind kind);
        int         n;
        int         k;
        logic [7:0] b;
        logic [7:0] x;
        line.delete();
        if (kind == SK_NOISE) begin
            n = $urandom_range(1, 20);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                line.push_back(b);
            end
        end else if (kind == SK_TINY) begin
            push_prefix($urandom_range(1, 7));
        end else begin
            push_prefix(7);
            push_digit(2); push_digit(9);
            push_digit(5); push_digit(9);
            push_digit(5); push_digit(9);
            if (kind == SK_STAR_STATUS) begin
                // pad byte steers the XOR so the first checksum digit reads 'A'
                x = body_xor();
                b = {x[7:4] ^ STATUS_NIBBLE, 4'($urandom_range(0, 15))};
                if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
                line.push_back(b);
                append_checksum();
            end else begin
                if ($urandom_range(0, 1)) begin
                    line.push_back(CH_DOT);
                    push_digit(9);
                    push_digit(9);
                end
                line.push_back(C_COMMA);
                if (kind != SK_NO_STATUS) begin
                    if ($urandom_range(0, 99) < 85) b = C_A;
                    else b = 8'($urandom_range(0, 255));
                    line.push_back(b);
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == C_STAR);
                        line.push_back(b);
                    end
                    if (kind != SK_NO_STAR) append_checksum();
                    if (kind == SK_SHORT_SUM) begin
                        n = $urandom_range(1, 2);
                        repeat (n) void'(line.pop_back());
                    end
                    if (kind == SK_BAD_SUM) begin
                        // a replacement may still alias to the same digit value
                        do b = 8'($urandom_range(0, 255)); while (b == line[line.size() - 1]);
                        line[line.size() - 1] = b;
                    end
                end
            end
            if (kind == SK_BAD_HDR) begin
                k = $urandom_range(0, 5);
                do b = 8'($urandom_range(0, 255)); while (b == line[k]);
                line[k] = b;
            end
            if (kind == SK_GOOD && $urandom_range(0, 3) == 0) begin
                line.push_back(CH_CR);
                line.push_back(CH_LF);
            end
        end
    endtask

    initial begin
        int             phase;
        int             random_items;
        int             random_sent;
        int             phase_items;
        int             phase_sent;
        int             r;
        logic [7:0]     x;
        logic [4:0]     zone_next;
        t_sentence_kind kind;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all-0xFF time field (largest time values, status after '*'
        // with the checksum's first digit as 'A'), a lone NUL ending a
        // one-character sentence, and a header whose checksum never arrives.
        line.delete();
        push_prefix(7);
        repeat (6) line.push_back(8'hFF);
        x = body_xor();
        line.push_back({x[7:4] ^ STATUS_NIBBLE, 4'h5});
        append_checksum();
        send_line();
        line.delete();
        line.push_back(8'h00);
        send_line();
        line.delete();
        push_prefix(6);
        line.push_back(C_STAR);
        send_line();

        // Random phases, each under its own zone offset; registers are only
        // written once the previous phase has fully drained.
        phase        = 0;
        random_items = 0;
        random_sent  = 0;
        while (random_items < RANDOM_ITEMS || random_sent < MIN_SENTENCES) begin
            if (phase > 0) begin
                case (phase)
                    1:       zone_next = 5'd0;
                    2:       zone_next = 5'd23;
                    3:       zone_next = 5'd31;
                    default: zone_next = 5'($urandom_range(0, 31));
                endcase
                cfg_write(zone_next);
            end
            // phase 2 runs flat out on both sides; phase 3 carries the hold-off
            send_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            recv_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            if (phase == 3) hold_req = 1'b1;

            phase_items = 0;
            phase_sent  = 0;
            while (phase_items < PHASE_ITEMS || phase_sent < PHASE_SENT) begin
                r = $urandom_range(0, 99);
                if (r < 60)      kind = SK_GOOD;
                else if (r < 65) kind = SK_BAD_SUM;
                else if (r < 70) kind = SK_BAD_HDR;
                else if (r < 74) kind = SK_NO_STAR;
                else if (r < 78) kind = SK_SHORT_SUM;
                else if (r < 82) kind = SK_NO_STATUS;
                else if (r < 88) kind = SK_STAR_STATUS;
                else if (r < 95) kind = SK_NOISE;
                else             kind = SK_TINY;
                make_sentence(kind);
                send_line();
                phase_items += line.size();
                phase_sent++;
            end
            in_valid <= 1'b0;
            drain();
            random_items += phase_items;
            random_sent  += phase_sent;
            phase++;
        end

        $display("Run covered %0d sentences in %0d characters over %0d phases;",
                 sentences_sent, chars_sent, phase);
        $display("%0d results checked, %0d accepted, %0d zone writes, %0d receiver hold-off.",
                 results_seen, accepted_seen, cfg_writes, holds_done);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
